[rtl/tap_hold_key_resolver_defines.svh]
// ----------------------------------------------------------------------------
// Tap-hold key resolver assertion macros
// Shorthand for clocked assertions, sampled on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAP_HOLD_KEY_RESOLVER_DEFINES_SVH
`define TAP_HOLD_KEY_RESOLVER_DEFINES_SVH

// same-cycle implication
`define THKR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define THKR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/thkr_pkg.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver package
// Field widths, command and action codes, register indexes, queue item type.
// ----------------------------------------------------------------------------
package thkr_pkg;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned PARAM_W = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned TERM_W  = 16;
	localparam int unsigned LAYER_W = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TAPPING_TERM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATE_LAYER   = 1'd1;

	localparam logic [TERM_W-1:0]  TERM_RESET = 16'd200;
	localparam logic [LAYER_W-1:0] NO_LAYER   = 8'd255;

	typedef enum logic [CMD_W-1:0] {
		CMD_DUAL_PRESS    = 2'd0,
		CMD_DUAL_RELEASE  = 2'd1,
		CMD_OTHER_PRESS   = 2'd2,
		CMD_OTHER_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_PRESS     = 2'd0,
		ACT_RELEASE   = 2'd1,
		ACT_LAYER_ON  = 2'd2,
		ACT_LAYER_OFF = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_DUAL_PRESS,
		OP_DUAL_RELEASE,
		OP_OTHER_PRESS
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [POS_W-1:0]   key_position;
		logic [PARAM_W-1:0] primary_param;
		logic [PARAM_W-1:0] secondary_param;
		logic [TIME_W-1:0]  time_ms;
	} item_t;

	typedef struct packed {
		logic  push;
		item_t item;
	} push_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INTR,
		ST_REL_FIRST,
		ST_REL_SECOND
	} st_t;

endpackage

[rtl/thkr_intf.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver channel interfaces
// Key event channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface thkr_evt_if;
	import thkr_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [POS_W-1:0]   key_position;
	logic [PARAM_W-1:0] primary_param;
	logic [PARAM_W-1:0] secondary_param;
	logic [TIME_W-1:0]  time_ms;

	modport source (output valid, cmd, key_position, primary_param, secondary_param, time_ms,
		input ready);
	modport sink (input valid, cmd, key_position, primary_param, secondary_param, time_ms,
		output ready);
endinterface

interface thkr_res_if;
	import thkr_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic               binding_index;
	logic [PARAM_W-1:0] param;
	logic [POS_W-1:0]   key_position_res;
	logic [LAYER_W-1:0] layer;
	logic               last;

	modport source (output valid, action, binding_index, param, key_position_res, layer, last,
		input ready);
	modport sink (input valid, action, binding_index, param, key_position_res, layer, last,
		output ready);
endinterface

[rtl/thkr_front.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver front end
// Accepts key event beats, drops other-key releases, classifies the rest.
// ----------------------------------------------------------------------------
module thkr_front (
	thkr_evt_if.sink        evt,
	input  logic            full,
	output thkr_pkg::push_t push_o
);
	import thkr_pkg::*;

	logic keep;
	op_t  op;

	always_comb begin
		keep = 1'b1;
		op   = OP_OTHER_PRESS;
		unique case (cmd_t'(evt.cmd))
			CMD_DUAL_PRESS:    op = OP_DUAL_PRESS;
			CMD_DUAL_RELEASE:  op = OP_DUAL_RELEASE;
			CMD_OTHER_PRESS:   op = OP_OTHER_PRESS;
			CMD_OTHER_RELEASE: keep = 1'b0;
			default:           keep = 1'b0;
		endcase
	end

	assign evt.ready = !full;

	always_comb begin
		push_o.push                 = evt.valid && !full && keep;
		push_o.item.op              = op;
		push_o.item.key_position    = evt.key_position;
		push_o.item.primary_param   = evt.primary_param;
		push_o.item.secondary_param = evt.secondary_param;
		push_o.item.time_ms         = evt.time_ms;
	end

endmodule

[rtl/thkr_queue.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver event queue
// Two-entry queue between front end and slot sequencer.
// ----------------------------------------------------------------------------
module thkr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  thkr_pkg::push_t push_i,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output thkr_pkg::item_t pop_item
);
	import thkr_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full     = cnt_q[1];
	assign nonempty = cnt_q != 2'd0;
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push  = push_i.push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_i.item;
	end

endmodule

[rtl/thkr_back.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver back end
// Holds the slot table, sequences interrupts and releases, registers results.
// ----------------------------------------------------------------------------
module thkr_back #(
	parameter int unsigned MAX_HELD = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  thkr_pkg::item_t              q_item,
	output logic                         q_pop,
	input  logic [thkr_pkg::TERM_W-1:0]  tapping_term,
	input  logic [thkr_pkg::LAYER_W-1:0] late_layer,
	thkr_res_if.source                   res
);
	import thkr_pkg::*;

	localparam int unsigned SW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

	function automatic logic [SW-1:0] lowest(input logic [MAX_HELD-1:0] v);
		logic [SW-1:0] idx;
		idx = '0;
		for (int i = MAX_HELD - 1; i >= 0; i--) begin
			if (v[i]) idx = SW'(i);
		end
		return idx;
	endfunction

	st_t state_q, state_d;

	logic [MAX_HELD-1:0] used_q;
	logic [MAX_HELD-1:0] intr_q, prim_q, layer_q;
	logic [POS_W-1:0]    pos_mem   [MAX_HELD];
	logic [PARAM_W-1:0]  p1_mem    [MAX_HELD];
	logic [PARAM_W-1:0]  p2_mem    [MAX_HELD];
	logic [TIME_W-1:0]   time_mem  [MAX_HELD];

	logic [MAX_HELD-1:0] mask_q;
	logic [TIME_W-1:0]   cur_time_q;
	action_t             rel_act_q;
	logic                rel_idx_q;
	logic [PARAM_W-1:0]  rel_param_q;
	logic [POS_W-1:0]    rel_pos_q;
	logic                rel_two_q;

	logic [MAX_HELD-1:0] cand, free_v, hit_v, sel_oh;
	logic [SW-1:0]       free_idx, hit_idx, sel_idx, rd_idx;
	logic                any_free, any_hit, mask_last, is_rel;
	logic [TIME_W-1:0]   now, elapsed;
	logic                passed, layer_en;
	logic                hit_layer, hit_prim, hit_intr;

	action_t             rel_act;
	logic                rel_idx;
	logic [PARAM_W-1:0]  rel_param;
	logic                rel_two, rel_any;

	logic                can_emit, fire;
	logic                emit_valid;
	action_t             emit_act;
	logic                emit_idx;
	logic [PARAM_W-1:0]  emit_param;
	logic [POS_W-1:0]    emit_pos;
	logic [LAYER_W-1:0]  emit_layer;
	logic                emit_last;
	logic                claim, intr_set;

	logic                res_valid_q;
	action_t             res_act_q;
	logic                res_idx_q;
	logic [PARAM_W-1:0]  res_param_q;
	logic [POS_W-1:0]    res_pos_q;
	logic [LAYER_W-1:0]  res_layer_q;
	logic                res_last_q;

	always_comb begin
		for (int i = 0; i < MAX_HELD; i++) begin
			cand[i]   = used_q[i] && (pos_mem[i] != q_item.key_position) && !intr_q[i];
			free_v[i] = !used_q[i];
			hit_v[i]  = used_q[i] && (pos_mem[i] == q_item.key_position);
		end
	end

	assign free_idx  = lowest(free_v);
	assign hit_idx   = lowest(hit_v);
	assign any_free  = |free_v;
	assign any_hit   = |hit_v;
	assign sel_idx   = lowest(mask_q);
	assign sel_oh    = mask_q & (~mask_q + MAX_HELD'(1));
	assign mask_last = (mask_q & ~sel_oh) == '0;
	assign is_rel    = q_item.op == OP_DUAL_RELEASE;

	// shared read index: release lookup while idle, interrupt target otherwise
	assign rd_idx   = (state_q == ST_IDLE) ? hit_idx : sel_idx;
	assign now      = (state_q == ST_IDLE) ? q_item.time_ms : cur_time_q;
	assign elapsed  = now - time_mem[rd_idx];
	assign passed   = elapsed >= TIME_W'(tapping_term);
	assign layer_en = late_layer != NO_LAYER;

	assign hit_layer = layer_q[hit_idx];
	assign hit_prim  = prim_q[hit_idx];
	assign hit_intr  = intr_q[hit_idx];

	always_comb begin
		rel_two   = !hit_layer && !hit_prim;
		rel_any   = hit_layer || hit_prim || !hit_intr;
		rel_idx   = rel_two && passed;
		if (hit_layer) begin
			rel_act   = ACT_LAYER_OFF;
			rel_param = '0;
		end else if (hit_prim) begin
			rel_act   = ACT_RELEASE;
			rel_param = p1_mem[hit_idx];
		end else begin
			rel_act   = ACT_PRESS;
			rel_param = passed ? p2_mem[hit_idx] : p1_mem[hit_idx];
		end
	end

	assign can_emit = !res_valid_q || res.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (is_rel) begin
						if (any_hit && rel_any) state_d = ST_REL_FIRST;
					end else if (|cand) begin
						state_d = ST_INTR;
					end
				end
			end
			ST_INTR: begin
				if (fire && mask_last) state_d = ST_IDLE;
			end
			ST_REL_FIRST: begin
				if (fire) state_d = rel_two_q ? ST_REL_SECOND : ST_IDLE;
			end
			ST_REL_SECOND: begin
				if (fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		emit_valid = 1'b0;
		emit_act   = ACT_PRESS;
		emit_idx   = 1'b0;
		emit_param = '0;
		emit_pos   = '0;
		emit_layer = '0;
		emit_last  = 1'b0;
		claim      = 1'b0;
		intr_set   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				claim = q_valid && (q_item.op == OP_DUAL_PRESS) && any_free;
			end
			ST_INTR: begin
				emit_valid = 1'b1;
				emit_pos   = pos_mem[rd_idx];
				emit_last  = mask_last;
				if (layer_en && passed) begin
					emit_act   = ACT_LAYER_ON;
					emit_layer = late_layer;
				end else begin
					emit_act   = ACT_PRESS;
					emit_param = p1_mem[rd_idx];
				end
				intr_set = can_emit;
			end
			ST_REL_FIRST: begin
				emit_valid = 1'b1;
				emit_act   = rel_act_q;
				emit_idx   = rel_idx_q;
				emit_param = rel_param_q;
				emit_pos   = rel_pos_q;
				emit_layer = (rel_act_q == ACT_LAYER_OFF) ? late_layer : '0;
				emit_last  = !rel_two_q;
			end
			ST_REL_SECOND: begin
				emit_valid = 1'b1;
				emit_act   = ACT_RELEASE;
				emit_idx   = rel_idx_q;
				emit_param = rel_param_q;
				emit_pos   = rel_pos_q;
				emit_last  = 1'b1;
			end
			default: q_pop = 1'b0;
		endcase
	end

	assign fire = emit_valid && can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (claim) used_q[free_idx] <= 1'b1;
			if (q_pop && is_rel && any_hit) used_q[hit_idx] <= 1'b0;
			if (can_emit) res_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			pos_mem[free_idx]  <= q_item.key_position;
			p1_mem[free_idx]   <= q_item.primary_param;
			p2_mem[free_idx]   <= q_item.secondary_param;
			time_mem[free_idx] <= q_item.time_ms;
			intr_q[free_idx]   <= 1'b0;
			prim_q[free_idx]   <= 1'b0;
			layer_q[free_idx]  <= 1'b0;
		end
		if (intr_set) begin
			intr_q[rd_idx] <= 1'b1;
			if (layer_en && passed) layer_q[rd_idx] <= 1'b1;
			else prim_q[rd_idx] <= 1'b1;
		end
		if (q_pop) begin
			mask_q      <= cand;
			cur_time_q  <= q_item.time_ms;
			rel_act_q   <= rel_act;
			rel_idx_q   <= rel_idx;
			rel_param_q <= rel_param;
			rel_pos_q   <= q_item.key_position;
			rel_two_q   <= rel_two;
		end else if (state_q == ST_INTR && fire) begin
			mask_q <= mask_q & ~sel_oh;
		end
		if (fire) begin
			res_act_q   <= emit_act;
			res_idx_q   <= emit_idx;
			res_param_q <= emit_param;
			res_pos_q   <= emit_pos;
			res_layer_q <= emit_layer;
			res_last_q  <= emit_last;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.action           = res_act_q;
	assign res.binding_index    = res_idx_q;
	assign res.param            = res_param_q;
	assign res.key_position_res = res_pos_q;
	assign res.layer            = res_layer_q;
	assign res.last             = res_last_q;

endmodule

[rtl/tap_hold_key_resolver.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver
// Key events in, binding and layer actions out for up to MAX_HELD dual keys.
// ----------------------------------------------------------------------------
// Events enter a two-entry queue at one beat per cycle until it fills, then
// a slot sequencer with a shared slot-table read index takes one event per
// pass: it dequeues the event, looks up and claims or frees a slot, then
// issues its results in turn (up to MAX_HELD for a press, up to two for a
// release), holding while the result side stalls, before taking the next.
// A registered result stage lets the sequencer move on while a result waits.
// Each event's last result is marked with last. Write the tapping term and
// the late-interrupt layer only while no event is in flight.
module tap_hold_key_resolver #(
	parameter int unsigned MAX_HELD = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	thkr_evt_if.sink                        evt,
	thkr_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [thkr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thkr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import thkr_pkg::*;

	logic [TERM_W-1:0]  tapping_term_q;
	logic [LAYER_W-1:0] late_layer_q;
	push_t              push;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	item_t              q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tapping_term_q <= TERM_RESET;
			late_layer_q   <= NO_LAYER;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAPPING_TERM: tapping_term_q <= cfg_data[TERM_W-1:0];
				REG_LATE_LAYER:   late_layer_q   <= cfg_data[LAYER_W-1:0];
				default: ;
			endcase
		end
	end

	thkr_front u_front (
		.evt    (evt),
		.full   (q_full),
		.push_o (push)
	);

	thkr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_i   (push),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_valid),
		.pop_item (q_item)
	);

	thkr_back #(
		.MAX_HELD (MAX_HELD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.tapping_term (tapping_term_q),
		.late_layer   (late_layer_q),
		.res          (res)
	);

endmodule

[rtl/thkr_checker.sv]
// ----------------------------------------------------------------------------
// Tap-hold key resolver port checker
// Result channel checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "tap_hold_key_resolver_defines.svh"

module thkr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [1:0]                     action,
	input logic                           binding_index,
	input logic [thkr_pkg::PARAM_W-1:0]   param,
	input logic [thkr_pkg::POS_W-1:0]     key_position_res,
	input logic [thkr_pkg::LAYER_W-1:0]   layer,
	input logic                           last
);
	import thkr_pkg::*;

	`THKR_ASSERT_NEXT(a_valid_hold, res_valid && !res_ready, res_valid, "result beat dropped")
	`THKR_ASSERT_NEXT(a_payload_hold, res_valid && !res_ready, $stable(action) && $stable(param) && $stable(key_position_res) && $stable(last), "stalled result changed")
	`THKR_ASSERT_IMPL(a_layer_fields, res_valid && (action == ACT_LAYER_ON || action == ACT_LAYER_OFF), binding_index == 1'b0 && param == '0, "layer action with binding fields")
	`THKR_ASSERT_IMPL(a_binding_layer, res_valid && (action == ACT_PRESS || action == ACT_RELEASE), layer == '0, "binding action with layer")
	`THKR_ASSERT_IMPL(a_hold_tap_pair, res_valid && action == ACT_PRESS && binding_index, !last, "secondary press not followed by release")

endmodule

bind tap_hold_key_resolver thkr_checker u_thkr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.action           (res.action),
	.binding_index    (res.binding_index),
	.param            (res.param),
	.key_position_res (res.key_position_res),
	.layer            (res.layer),
	.last             (res.last)
);

[verif/tap_hold_key_resolver_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tap-hold key resolver testbench
// Drives key events into the resolver and predicts the binding and layer
// actions each event causes from a slot table kept alongside the block. Every
// result beat is checked field by field in order. A directed set of events
// comes first, then random event streams over several register settings and
// handshake idling patterns, including a long result-side hold-off.
// ----------------------------------------------------------------------------
module tap_hold_key_resolver_tb;
	import thkr_pkg::*;

	localparam int SLOTS          = 4;
	localparam int SETTLE_CYCLES  = 16;
	localparam int STALL_LIMIT    = 4000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int PHASE_EVENTS   = 64;
	localparam int PHASES         = 6;

	typedef struct {
		cmd_t               cmd;
		logic [POS_W-1:0]   pos;
		logic [PARAM_W-1:0] primary;
		logic [PARAM_W-1:0] secondary;
		logic [TIME_W-1:0]  stamp;
	} key_event_t;

	typedef struct {
		action_t            action;
		logic               binding;
		logic [PARAM_W-1:0] param;
		logic [POS_W-1:0]   pos;
		logic [LAYER_W-1:0] layer;
		logic               last;
	} key_action_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	thkr_evt_if evt();
	thkr_res_if res();

	tap_hold_key_resolver #(.MAX_HELD(SLOTS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// resolver state as the block should hold it
	logic [TERM_W-1:0]  term_ms;
	logic [LAYER_W-1:0] intr_layer;
	logic               held_used      [SLOTS];
	logic [POS_W-1:0]   held_pos       [SLOTS];
	logic [PARAM_W-1:0] held_primary   [SLOTS];
	logic [PARAM_W-1:0] held_secondary [SLOTS];
	logic [TIME_W-1:0]  held_press     [SLOTS];
	logic               held_intr      [SLOTS];
	logic               held_prim      [SLOTS];
	logic               held_layer     [SLOTS];

	key_event_t  pending_events[$];
	key_action_t expected_actions[$];
	logic [POS_W-1:0] gen_held[$];
	logic [TIME_W-1:0] gen_now;

	key_event_t  outgoing;
	key_event_t  seen_event;
	key_action_t want;

	int   error_count  = 0;
	int   quiet_cycles = 0;
	int   tx_idle_pct  = 0;
	int   rx_idle_pct  = 0;
	int   rx_hold_left = 0;
	logic rx_hold_req  = 1'b0;
	logic rx_hold_done = 1'b0;
	logic evt_beat     = 1'b0;
	logic res_beat     = 1'b0;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_val));
	endtask

	function automatic void add_action(action_t act, logic binding, logic [PARAM_W-1:0] prm,
		logic [POS_W-1:0] pos, logic [LAYER_W-1:0] lyr);
		key_action_t r;
		r.action  = act;
		r.binding = binding;
		r.param   = prm;
		r.pos     = pos;
		r.layer   = lyr;
		r.last    = 1'b0;
		expected_actions.push_back(r);
	endfunction

	function automatic logic term_elapsed(int s, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		elapsed = now - held_press[s];
		return elapsed >= 32'(term_ms);
	endfunction

	function automatic void resolve_event(key_event_t e);
		int          depth;
		int          hit;
		logic        claimed;
		logic        late;
		key_action_t r;
		depth = expected_actions.size();
		if (e.cmd == CMD_DUAL_PRESS || e.cmd == CMD_OTHER_PRESS) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (held_used[s] && held_pos[s] != e.pos && !held_intr[s]) begin
					held_intr[s] = 1'b1;
					if (intr_layer != NO_LAYER && term_elapsed(s, e.stamp)) begin
						add_action(ACT_LAYER_ON, 1'b0, '0, held_pos[s], intr_layer);
						held_layer[s] = 1'b1;
					end else begin
						add_action(ACT_PRESS, 1'b0, held_primary[s], held_pos[s], '0);
						held_prim[s] = 1'b1;
					end
				end
			end
			if (e.cmd == CMD_DUAL_PRESS) begin
				claimed = 1'b0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!claimed && !held_used[s]) begin
						held_used[s]      = 1'b1;
						held_pos[s]       = e.pos;
						held_primary[s]   = e.primary;
						held_secondary[s] = e.secondary;
						held_press[s]     = e.stamp;
						held_intr[s]      = 1'b0;
						held_prim[s]      = 1'b0;
						held_layer[s]     = 1'b0;
						claimed           = 1'b1;
					end
				end
			end
		end else if (e.cmd == CMD_DUAL_RELEASE) begin
			hit = -1;
			for (int s = 0; s < SLOTS; s++)
				if (hit < 0 && held_used[s] && held_pos[s] == e.pos)
					hit = s;
			if (hit >= 0) begin
				if (held_layer[hit]) begin
					add_action(ACT_LAYER_OFF, 1'b0, '0, e.pos, intr_layer);
				end else if (held_prim[hit]) begin
					add_action(ACT_RELEASE, 1'b0, held_primary[hit], e.pos, '0);
				end else if (!held_intr[hit]) begin
					late = term_elapsed(hit, e.stamp);
					add_action(ACT_PRESS, late,
						late ? held_secondary[hit] : held_primary[hit], e.pos, '0);
					add_action(ACT_RELEASE, late,
						late ? held_secondary[hit] : held_primary[hit], e.pos, '0);
				end
				held_used[hit] = 1'b0;
			end
		end
		if (expected_actions.size() > depth) begin
			r = expected_actions.pop_back();
			r.last = 1'b1;
			expected_actions.push_back(r);
		end
	endfunction

	// advance the event queue one beat at a time
	always @(negedge clk) begin
		if (!arst_n) begin
			evt.valid           <= 1'b0;
			evt.cmd             <= '0;
			evt.key_position    <= '0;
			evt.primary_param   <= '0;
			evt.secondary_param <= '0;
			evt.time_ms         <= '0;
		end else if (!evt.valid || evt_beat) begin
			if (pending_events.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				outgoing = pending_events.pop_front();
				evt.valid           <= 1'b1;
				evt.cmd             <= outgoing.cmd;
				evt.key_position    <= outgoing.pos;
				evt.primary_param   <= outgoing.primary;
				evt.secondary_param <= outgoing.secondary;
				evt.time_ms         <= outgoing.stamp;
			end else begin
				evt.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold_req && !rx_hold_done) begin
			rx_hold_left = RX_HOLD_CYCLES;
			rx_hold_done = 1'b1;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				held_used[s] = 1'b0;
		end
		evt_beat = arst_n && evt.valid && evt.ready;
		res_beat = arst_n && res.valid && res.ready;
		if (res_beat) begin
			if (expected_actions.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat, action %0d position %0h",
					res.action, res.key_position_res));
			end else begin
				want = expected_actions.pop_front();
				check_field("action", res.action, want.action);
				check_field("binding_index", res.binding_index, want.binding);
				check_field("param", res.param, want.param);
				check_field("key_position_res", res.key_position_res, want.pos);
				check_field("layer", res.layer, want.layer);
				check_field("last", res.last, want.last);
			end
		end
		if (evt_beat) begin
			seen_event.cmd       = cmd_t'(evt.cmd);
			seen_event.pos       = evt.key_position;
			seen_event.primary   = evt.primary_param;
			seen_event.secondary = evt.secondary_param;
			seen_event.stamp     = evt.time_ms;
			resolve_event(seen_event);
		end
		if (evt_beat || res_beat)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_event(cmd_t cmd, logic [POS_W-1:0] pos, logic [PARAM_W-1:0] p1,
		logic [PARAM_W-1:0] p2, logic [TIME_W-1:0] stamp);
		key_event_t e;
		e.cmd       = cmd;
		e.pos       = pos;
		e.primary   = p1;
		e.secondary = p2;
		e.stamp     = stamp;
		pending_events.push_back(e);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_TAPPING_TERM)
			term_ms = data;
		else
			intr_layer = data[LAYER_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || evt.valid || expected_actions.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 11));
	endfunction

	function automatic logic [POS_W-1:0] pick_held();
		return gen_held[$urandom_range(0, gen_held.size() - 1)];
	endfunction

	// mostly steps near the tapping term, sometimes a jump anywhere
	function automatic void advance_clock();
		logic [TIME_W-1:0] dt;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: dt = $urandom_range(0, term_ms / 2);
			4: dt = 32'(term_ms) - 1;
			5: dt = 32'(term_ms);
			6: dt = 32'(term_ms) + 1;
			7, 8: dt = $urandom_range(term_ms, 2 * term_ms + 10);
			default: dt = $urandom;
		endcase
		gen_now += dt;
	endfunction

	task automatic queue_random(int count);
		int         made;
		int         pick;
		int         idx;
		key_event_t e;
		made = 0;
		while (made < count) begin
			advance_clock();
			e.primary   = $urandom;
			e.secondary = $urandom;
			e.stamp     = gen_now;
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				e.cmd = CMD_DUAL_PRESS;
				if (gen_held.size() != 0 && $urandom_range(0, 4) == 0)
					e.pos = pick_held();
				else
					e.pos = pick_position();
				gen_held.push_back(e.pos);
				if (gen_held.size() > 8)
					void'(gen_held.pop_front());
			end else if (pick < 76) begin
				e.cmd = CMD_DUAL_RELEASE;
				if (gen_held.size() != 0) begin
					idx   = $urandom_range(0, gen_held.size() - 1);
					e.pos = gen_held[idx];
					gen_held.delete(idx);
				end else begin
					e.pos = pick_position();
				end
			end else if (pick < 92) begin
				e.cmd = CMD_OTHER_PRESS;
				if (gen_held.size() != 0 && $urandom_range(0, 1) == 0)
					e.pos = pick_held();
				else
					e.pos = 8'($urandom_range(0, 255));
			end else if (pick < 96) begin
				e.cmd = CMD_OTHER_RELEASE;
				e.pos = 8'($urandom_range(0, 255));
			end else begin
				e.cmd = CMD_DUAL_RELEASE;
				e.pos = 8'($urandom_range(0, 255));
			end
			pending_events.push_back(e);
			if (e.cmd != CMD_OTHER_RELEASE)
				made++;
		end
	endtask

	task automatic run_directed();
		// tap one short of the term, then hold exactly to the term across the wrap
		queue_event(CMD_DUAL_PRESS, 8'h00, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FF00);
		queue_event(CMD_DUAL_RELEASE, 8'h00, 32'h0, 32'h0, 32'hFFFF_FF00 + 199);
		queue_event(CMD_DUAL_PRESS, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		queue_event(CMD_DUAL_RELEASE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0 + 200);
		// release with nothing held, other key release
		queue_event(CMD_DUAL_RELEASE, 8'h55, 32'h0, 32'h0, 32'h100);
		queue_event(CMD_OTHER_RELEASE, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h101);
		// fill the table, press into a full table, release all
		for (int i = 1; i <= SLOTS; i++)
			queue_event(CMD_DUAL_PRESS, 8'(i), 32'h1000 + i, 32'h2000 + i, 32'h200 + i);
		queue_event(CMD_DUAL_PRESS, 8'h05, 32'h1005, 32'h2005, 32'h300);
		for (int i = 1; i <= SLOTS; i++)
			queue_event(CMD_DUAL_RELEASE, 8'(i), 32'h0, 32'h0, 32'h400);
		// same position in every entry, one other press interrupts all of them
		for (int i = 0; i < SLOTS; i++)
			queue_event(CMD_DUAL_PRESS, 8'hAA, $urandom, $urandom, 32'h500 + i);
		queue_event(CMD_OTHER_PRESS, 8'h7E, 32'h0, 32'h0, 32'h510);
		for (int i = 0; i < SLOTS; i++)
			queue_event(CMD_DUAL_RELEASE, 8'hAA, 32'h0, 32'h0, 32'h600);
		wait_drained();
		// late interrupt with a layer configured
		write_register(REG_LATE_LAYER, 16'd9);
		queue_event(CMD_DUAL_PRESS, 8'h20, 32'hA5A5_0001, 32'h5A5A_0002, 32'h1000);
		queue_event(CMD_OTHER_PRESS, 8'h21, 32'h0, 32'h0, 32'h1000 + 300);
		queue_event(CMD_DUAL_RELEASE, 8'h20, 32'h0, 32'h0, 32'h2000);
		wait_drained();
		gen_now = 32'h2000;
	endtask

	initial begin
		logic [TERM_W-1:0]  term_set;
		logic [LAYER_W-1:0] layer_set;
		clk       = 1'b0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		term_ms    = TERM_RESET;
		intr_layer = NO_LAYER;
		tx_idle_pct = 32;
		rx_idle_pct = 51;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin term_set = 16'd200;   layer_set = 8'd9;   end
				1: begin term_set = 16'd0;     layer_set = 8'd0;   end
				2: begin term_set = 16'd65535; layer_set = 8'd254; end
				3: begin term_set = 16'd30;    layer_set = NO_LAYER; end
				4: begin term_set = 16'd1;     layer_set = 8'd128; end
				default: begin term_set = 16'd500; layer_set = 8'd77; end
			endcase
			if (ph < 2) begin
				tx_idle_pct = 32;
				rx_idle_pct = 51;
			end else if (ph < 4) begin
				tx_idle_pct = 51;
				rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_register(REG_TAPPING_TERM, term_set);
			write_register(REG_LATE_LAYER, {8'($urandom), layer_set});
			if (ph == 4) begin
				// hold results off while events keep coming, then pause the sender
				@(posedge clk);
				rx_hold_req = 1'b1;
				queue_random(PHASE_EVENTS / 2);
				wait_drained();
				queue_random(PHASE_EVENTS / 2);
			end else begin
				queue_random(PHASE_EVENTS);
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_actions.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
